@@ src/spq_pkg.sv @@
package spq_pkg;

  // Default store depth
  localparam int unsigned CAPACITY_DEF = 16;

  // Fixed field widths
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned OCC_W  = 5;

  // Request modes
  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PLACE,
    ST_DEQ
  } state_e;

  // Result handed from the sequencer to the output register
  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [STAT_W-1:0] status;
    logic [OCC_W-1:0]  occ;
  } res_t;

endpackage

@@ src/spq_ram.sv @@
module spq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/spq_seq.sv @@
module spq_seq import spq_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  localparam int unsigned IW = $clog2(CAPACITY),
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             mode_i,
  input  logic [KEY_W-1:0] key_i,
  input  logic             out_free_i,
  output res_t             res_o,
  output logic             ram_we_o,
  output logic [IW-1:0]    ram_waddr_o,
  output logic [KEY_W-1:0] ram_wdata_o,
  output logic             ram_re_o,
  output logic [IW-1:0]    ram_raddr_o,
  input  logic [KEY_W-1:0] ram_rdata_i
);

  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);
  localparam logic [IW:0]   CAP_SUM  = (IW+1)'(CAPACITY);

  state_e           state_q, state_d;
  logic [IW-1:0]    head_q, head_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [IW-1:0]    rd_q, rd_d;
  logic [CW-1:0]    rem_q, rem_d;
  logic [KEY_W-1:0] key_q, key_d;

  logic [IW:0]      tail_sum;
  logic [IW-1:0]    tail;
  logic [IW-1:0]    last;
  logic             accept;
  logic             greater;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] a);
    return (a == LAST_IDX) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [IW-1:0] wrap_dec(input logic [IW-1:0] a);
    return (a == '0) ? LAST_IDX : a - 1'b1;
  endfunction

  // Physical slot after the newest key
  always_comb begin
    tail_sum = {1'b0, head_q} + (IW+1)'(cnt_q);
    if (tail_sum >= CAP_SUM) begin
      tail_sum = tail_sum - CAP_SUM;
    end
  end
  assign tail = tail_sum[IW-1:0];
  assign last = wrap_dec(tail);

  // Take a request only when idle with room in the output register
  assign accept  = (state_q == ST_IDLE) && in_valid_i && out_free_i;
  assign greater = $signed(ram_rdata_i) > $signed(key_q);

  // State and pointer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      cnt_q   <= '0;
      rd_q    <= '0;
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      rd_q    <= rd_d;
      rem_q   <= rem_d;
    end
  end

  // Key under insertion
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  // Next state, memory control and result
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    rd_d        = rd_q;
    rem_d       = rem_q;
    key_d       = key_q;
    in_stall_o  = 1'b1;
    ram_we_o    = 1'b0;
    ram_waddr_o = tail;
    ram_wdata_o = key_i;
    ram_re_o    = 1'b0;
    ram_raddr_o = head_q;
    res_o       = '0;

    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = !out_free_i;
        if (accept) begin
          if (mode_i == MODE_DEQ) begin
            if (cnt_q == '0) begin
              res_o.valid  = 1'b1;
              res_o.status = STAT_EMPTY;
              res_o.occ    = OCC_W'(cnt_q);
            end else begin
              // Fetch the front key
              ram_re_o    = 1'b1;
              ram_raddr_o = head_q;
              state_d     = ST_DEQ;
            end
          end else if (cnt_q == CAP_CNT) begin
            // Drop the key, store is full
            res_o.valid  = 1'b1;
            res_o.status = STAT_FULL;
            res_o.occ    = OCC_W'(cnt_q);
          end else if (cnt_q == '0) begin
            // Empty store: write directly
            ram_we_o     = 1'b1;
            ram_waddr_o  = tail;
            ram_wdata_o  = key_i;
            cnt_d        = cnt_q + 1'b1;
            res_o.valid  = 1'b1;
            res_o.status = STAT_OK;
            res_o.occ    = OCC_W'(cnt_d);
          end else begin
            // Start the backward scan at the newest key
            ram_re_o    = 1'b1;
            ram_raddr_o = last;
            rd_d        = last;
            rem_d       = cnt_q;
            key_d       = key_i;
            state_d     = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (greater) begin
          // Shift the larger key one slot back
          ram_we_o    = 1'b1;
          ram_waddr_o = wrap_inc(rd_q);
          ram_wdata_o = ram_rdata_i;
          if (rem_q == CW'(1)) begin
            state_d = ST_PLACE;
          end else begin
            ram_re_o    = 1'b1;
            ram_raddr_o = wrap_dec(rd_q);
            rd_d        = wrap_dec(rd_q);
            rem_d       = rem_q - 1'b1;
          end
        end else if (out_free_i) begin
          // Insert behind the first key not greater than it
          ram_we_o     = 1'b1;
          ram_waddr_o  = wrap_inc(rd_q);
          ram_wdata_o  = key_q;
          cnt_d        = cnt_q + 1'b1;
          res_o.valid  = 1'b1;
          res_o.status = STAT_OK;
          res_o.occ    = OCC_W'(cnt_d);
          state_d      = ST_IDLE;
        end
      end

      ST_PLACE: begin
        if (out_free_i) begin
          // Key becomes the new front
          ram_we_o     = 1'b1;
          ram_waddr_o  = rd_q;
          ram_wdata_o  = key_q;
          cnt_d        = cnt_q + 1'b1;
          res_o.valid  = 1'b1;
          res_o.status = STAT_OK;
          res_o.occ    = OCC_W'(cnt_d);
          state_d      = ST_IDLE;
        end
      end

      ST_DEQ: begin
        if (out_free_i) begin
          // Retire the front key
          head_d       = wrap_inc(head_q);
          cnt_d        = cnt_q - 1'b1;
          res_o.valid  = 1'b1;
          res_o.key    = ram_rdata_i;
          res_o.status = STAT_OK;
          res_o.occ    = OCC_W'(cnt_d);
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Results only leave when the output register can take them
  a_res_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> out_free_i)
    else $error("result issued while output register blocked");

  // Count never exceeds the store depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CAP_CNT)
    else $error("key count above capacity");

  // A full drop only happens with a full store
  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.status == STAT_FULL) |-> cnt_q == CAP_CNT)
    else $error("full status with room left");

  // Scan always has an entry left to compare
  a_scan_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> (rem_q != '0 && rem_q <= cnt_q))
    else $error("scan outside stored keys");

  // Dequeue completion lowers the count by one
  a_deq_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DEQ && out_free_i) |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("dequeue count update wrong");

endmodule

@@ src/sorted_priority_queue.sv @@
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_stall_o    mode_i, key_in_i
// out      output     out_valid_o / out_stall_i  key_out_o, status_o, occupancy_o
//
// Enqueue into an empty store, any drop and any empty dequeue finish in the
// accepting cycle. Dequeue: ST_IDLE, ST_DEQ (one registered front-slot read).
// Other enqueues: ST_IDLE, ST_SCAN while held keys exceed the new one, and
// the write in ST_SCAN or ST_PLACE; the store RAM moves one key per cycle
// through its single read port. Reset empties the queue at once; the store
// contents need no clearing. The input stalls while an item is in progress,
// and also while a stalled result holds the output register, until taken.
module sorted_priority_queue import spq_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     mode_i,
  input  logic signed [KEY_W-1:0]  key_in_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [KEY_W-1:0]  key_out_o,
  output logic        [STAT_W-1:0] status_o,
  output logic        [OCC_W-1:0]  occupancy_o
);

  localparam int unsigned IW = $clog2(CAPACITY);

  res_t             res;
  res_t             out_q;
  logic             out_valid_q;
  logic             out_free;
  logic             ram_we;
  logic [IW-1:0]    ram_waddr;
  logic [KEY_W-1:0] ram_wdata;
  logic             ram_re;
  logic [IW-1:0]    ram_raddr;
  logic [KEY_W-1:0] ram_rdata;

  spq_seq #(
    .CAPACITY(CAPACITY)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .key_i       (key_in_i),
    .out_free_i  (out_free),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  spq_ram #(
    .WIDTH(KEY_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  // Output valid: load on a new result, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload: hold while stalled
  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign key_out_o   = $signed(out_q.key);
  assign status_o    = out_q.status;
  assign occupancy_o = out_q.occ;

endmodule
